@@ rtl/wnp_pkg.sv @@
// Shared constants, types and width helpers for the winding-number point-in-polygon block.
package wnp_pkg;

	localparam int DEF_MAX_EDGES    = 16;
	localparam int DEF_COORD_WIDTH  = 16;
	localparam int WN_W             = 6;
	localparam int WN_MAX           = 31;
	localparam int WN_MIN           = -32;
	localparam int EDGE_COUNT_RESET = 4;
	localparam int QUEUE_DEPTH      = 2;

	typedef enum logic [0:0] {
		CMD_WRITE = 1'b0,
		CMD_TEST  = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic int idx_w(input int max_edges);
		return $clog2(max_edges + 1);
	endfunction

	function automatic int cnt_w(input int max_edges);
		return ($clog2(max_edges + 1) > 3) ? $clog2(max_edges + 1) : 3;
	endfunction

endpackage

@@ rtl/wnp_front.sv @@
// Front end: takes requests, drops out-of-range vertex writes, hands commands to the queue.
module wnp_front #(
	parameter int MAX_EDGES   = wnp_pkg::DEF_MAX_EDGES,
	parameter int COORD_WIDTH = wnp_pkg::DEF_COORD_WIDTH,
	parameter int CMD_W       = 1 + wnp_pkg::idx_w(MAX_EDGES) + 2 * COORD_WIDTH
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic                                    req_type,
	input  logic [wnp_pkg::idx_w(MAX_EDGES)-1:0]    vertex_index,
	input  logic signed [COORD_WIDTH-1:0]           coord_x,
	input  logic signed [COORD_WIDTH-1:0]           coord_y,
	input  wnp_pkg::q_stat_t                        q_stat,
	output logic                                    push,
	output logic [CMD_W-1:0]                        push_data
);
	import wnp_pkg::*;

	localparam int IDX_W = idx_w(MAX_EDGES);

	logic             cmd_vld_q;
	logic [CMD_W-1:0] cmd_q;
	logic             accept;
	logic             keep;
	cmd_kind_t        kind;

	assign busy   = cmd_vld_q && q_stat.full;
	assign accept = start && !busy;
	assign push   = cmd_vld_q && !q_stat.full;
	assign push_data = cmd_q;

	always_comb begin
		kind = req_type ? CMD_TEST : CMD_WRITE;
		// drop writes to slots beyond the store
		keep = (kind == CMD_TEST) || (vertex_index <= IDX_W'(MAX_EDGES));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_vld_q <= 1'b0;
		end else if (accept) begin
			cmd_vld_q <= keep;
		end else if (push) begin
			cmd_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= {kind, vertex_index, coord_x, coord_y};
		end
	end

endmodule

@@ rtl/wnp_queue.sv @@
// Short command queue between the front end and the edge walker.
module wnp_queue #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	input  logic              pop,
	output logic [DATA_W-1:0] pop_data,
	output wnp_pkg::q_stat_t  q_stat
);
	import wnp_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [DATA_W-1:0] slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign q_stat.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign do_push = push && !q_stat.full;
	assign do_pop  = pop && !q_stat.empty;
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ rtl/wnp_back.sv @@
// Back end: vertex store, edge walk pipeline, crossing tests and winding accumulation.
module wnp_back #(
	parameter int MAX_EDGES   = wnp_pkg::DEF_MAX_EDGES,
	parameter int COORD_WIDTH = wnp_pkg::DEF_COORD_WIDTH,
	parameter int CMD_W       = 1 + wnp_pkg::idx_w(MAX_EDGES) + 2 * COORD_WIDTH
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  wnp_pkg::q_stat_t                        q_stat,
	input  logic [CMD_W-1:0]                        pop_data,
	output logic                                    pop,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [wnp_pkg::cnt_w(MAX_EDGES)-1:0]    cfg_data,
	output logic                                    done,
	output logic signed [wnp_pkg::WN_W-1:0]         winding_number,
	output logic                                    inside_res
);
	import wnp_pkg::*;

	localparam int CW     = COORD_WIDTH;
	localparam int DEPTH  = MAX_EDGES + 1;
	localparam int IDX_W  = idx_w(MAX_EDGES);
	localparam int CNT_W  = cnt_w(MAX_EDGES);
	localparam int DW     = CW + 1;
	localparam int MW     = 2 * DW;
	localparam int PW     = MW + 1;
	localparam int ACC_W0 = $clog2(MAX_EDGES + 1) + 2;
	localparam int ACC_W  = (ACC_W0 > WN_W) ? ACC_W0 : WN_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN
	} state_t;

	state_t state_q;

	// command head
	cmd_kind_t               head_kind;
	logic [IDX_W-1:0]        head_idx;
	logic signed [CW-1:0]    head_x;
	logic signed [CW-1:0]    head_y;

	logic [CNT_W-1:0]        edge_count_q;
	logic [IDX_W-1:0]        n_sat;
	logic [IDX_W-1:0]        n_q;
	logic [IDX_W-1:0]        addr_q;
	logic signed [CW-1:0]    px_q;
	logic signed [CW-1:0]    py_q;

	logic [2*CW-1:0]         vmem [DEPTH];
	logic                    mem_we;
	logic                    rd_en;
	logic                    rd_last;

	// stage 1: vertex read
	logic [2*CW-1:0]         rd_data_s1;
	logic                    vld_s1;
	logic                    first_s1;
	logic                    last_s1;
	logic signed [CW-1:0]    cur_x;
	logic signed [CW-1:0]    cur_y;
	logic signed [CW-1:0]    prev_x_q;
	logic signed [CW-1:0]    prev_y_q;

	// stage 2: differences and crossing direction
	logic                    vld_s2;
	logic                    last_s2;
	logic                    up_s2;
	logic                    dn_s2;
	logic signed [DW-1:0]    dxe_s2;
	logic signed [DW-1:0]    dyp_s2;
	logic signed [DW-1:0]    dxp_s2;
	logic signed [DW-1:0]    dye_s2;

	// stage 3: products
	logic                    vld_s3;
	logic                    last_s3;
	logic                    up_s3;
	logic                    dn_s3;
	logic signed [MW-1:0]    p1_s3;
	logic signed [MW-1:0]    p2_s3;

	logic signed [PW-1:0]    cross_sum;
	logic                    cross_pos;
	logic                    cross_neg;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] acc_nxt;
	logic signed [ACC_W-1:0] acc_clamp;
	logic signed [ACC_W-1:0] wn_hi;
	logic signed [ACC_W-1:0] wn_lo;

	logic                    done_q;
	logic signed [WN_W-1:0]  wn_q;
	logic                    inside_q;

	assign head_kind = cmd_kind_t'(pop_data[CMD_W-1]);
	assign head_idx  = pop_data[2*CW +: IDX_W];
	assign head_x    = pop_data[CW +: CW];
	assign head_y    = pop_data[0 +: CW];

	assign pop     = (state_q == ST_IDLE) && !q_stat.empty;
	assign mem_we  = pop && (head_kind == CMD_WRITE);
	assign rd_en   = (state_q == ST_WALK);
	assign rd_last = (addr_q == n_q);
	assign n_sat   = (edge_count_q > CNT_W'(MAX_EDGES)) ? IDX_W'(MAX_EDGES)
	                                                     : IDX_W'(edge_count_q);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_count_q <= CNT_W'(EDGE_COUNT_RESET);
		end else if (cfg_valid && cfg_ready) begin
			edge_count_q <= cfg_data;
		end
	end

	// vertex store, one write or one read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			vmem[head_idx] <= {head_x, head_y};
		end
		if (rd_en) begin
			rd_data_s1 <= vmem[addr_q];
		end
	end

	assign cur_x = rd_data_s1[CW +: CW];
	assign cur_y = rd_data_s1[0 +: CW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			first_s1 <= 1'b0;
			last_s1 <= 1'b0;
			last_s2 <= 1'b0;
			last_s3 <= 1'b0;
		end else begin
			vld_s1   <= rd_en;
			first_s1 <= rd_en && (addr_q == '0);
			last_s1  <= rd_en && rd_last;
			vld_s2   <= vld_s1 && !first_s1;
			last_s2  <= vld_s1 && last_s1;
			vld_s3   <= vld_s2;
			last_s3  <= vld_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			prev_x_q <= cur_x;
			prev_y_q <= cur_y;
			dxe_s2 <= DW'(cur_x) - DW'(prev_x_q);
			dyp_s2 <= DW'(py_q) - DW'(prev_y_q);
			dxp_s2 <= DW'(px_q) - DW'(prev_x_q);
			dye_s2 <= DW'(cur_y) - DW'(prev_y_q);
			up_s2  <= (prev_y_q <= py_q) && (cur_y > py_q);
			dn_s2  <= (prev_y_q > py_q) && (cur_y <= py_q);
		end
		if (vld_s2) begin
			p1_s3 <= MW'(dxe_s2) * MW'(dyp_s2);
			p2_s3 <= MW'(dxp_s2) * MW'(dye_s2);
			up_s3 <= up_s2;
			dn_s3 <= dn_s2;
		end
	end

	always_comb begin
		cross_sum = PW'(p1_s3) - PW'(p2_s3);
		cross_neg = cross_sum[PW-1];
		cross_pos = !cross_sum[PW-1] && (cross_sum != '0);
		if (up_s3 && cross_pos) begin
			acc_nxt = acc_q + ACC_W'(1);
		end else if (dn_s3 && cross_neg) begin
			acc_nxt = acc_q - ACC_W'(1);
		end else begin
			acc_nxt = acc_q;
		end
		wn_hi = ACC_W'(WN_MAX);
		wn_lo = ACC_W'(WN_MIN);
		if (acc_nxt > wn_hi) begin
			acc_clamp = wn_hi;
		end else if (acc_nxt < wn_lo) begin
			acc_clamp = wn_lo;
		end else begin
			acc_clamp = acc_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			n_q      <= '0;
			addr_q   <= '0;
			px_q     <= '0;
			py_q     <= '0;
			acc_q    <= '0;
			done_q   <= 1'b0;
			wn_q     <= '0;
			inside_q <= 1'b0;
		end else begin
			done_q <= ((state_q == ST_IDLE) && pop && (head_kind == CMD_TEST) && (n_sat == '0)) ||
			          ((state_q == ST_DRAIN) && vld_s3 && last_s3);
			if (vld_s3) begin
				acc_q <= acc_nxt;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop && (head_kind == CMD_TEST)) begin
						px_q  <= head_x;
						py_q  <= head_y;
						acc_q <= '0;
						if (n_sat == '0) begin
							wn_q     <= '0;
							inside_q <= 1'b0;
						end else begin
							n_q     <= n_sat;
							addr_q  <= '0;
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (rd_last) begin
						state_q <= ST_DRAIN;
					end else begin
						addr_q <= addr_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					if (vld_s3 && last_s3) begin
						wn_q     <= WN_W'(acc_clamp);
						inside_q <= (acc_nxt != '0);
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done           = done_q;
	assign winding_number = wn_q;
	assign inside_res     = inside_q;

endmodule

@@ rtl/winding_number_point_in_polygon.sv @@
// Top level of the winding-number point-in-polygon block.
// Requests enter when start is high and busy is low; results leave on the done strobe for one
// cycle and cannot be held off, so capture them on that cycle. A vertex write (req_type 0)
// fills one slot of the vertex store and produces no result; slots above MAX_EDGES are dropped.
// A test (req_type 1) walks edges 0..N-1, N being edge_count clamped to MAX_EDGES, and returns
// the signed winding number (clamped to -32..31) with inside_res set when it is nonzero. Write
// vertex N equal to vertex 0 to close the polygon, and write every vertex a test reads. A test
// occupies the edge walker from the cycle it leaves the queue: N+1 reads from the single-port
// vertex store, three pipeline stages, then the result register. A test with N of zero answers
// in the cycle after it leaves the queue, and a write is stored as it leaves the queue. The
// two-entry queue lets a few requests be taken while a test is still walking; busy rises once
// it is full and the front end holds a further request. edge_count may be written through
// cfg_valid/cfg_data, which is always ready, while no request is outstanding.
module winding_number_point_in_polygon #(
	parameter int MAX_EDGES   = wnp_pkg::DEF_MAX_EDGES,
	parameter int COORD_WIDTH = wnp_pkg::DEF_COORD_WIDTH
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic                                    req_type,
	input  logic [wnp_pkg::idx_w(MAX_EDGES)-1:0]    vertex_index,
	input  logic signed [COORD_WIDTH-1:0]           coord_x,
	input  logic signed [COORD_WIDTH-1:0]           coord_y,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [wnp_pkg::cnt_w(MAX_EDGES)-1:0]    cfg_data,
	output logic                                    done,
	output logic signed [wnp_pkg::WN_W-1:0]         winding_number,
	output logic                                    inside_res
);
	import wnp_pkg::*;

	// command word: kind, slot index, x, y
	localparam int CMD_W = 1 + idx_w(MAX_EDGES) + 2 * COORD_WIDTH;

	q_stat_t          q_stat;
	logic             push;
	logic [CMD_W-1:0] push_data;
	logic             pop;
	logic [CMD_W-1:0] pop_data;

	// classify and hand over requests
	wnp_front #(
		.MAX_EDGES   (MAX_EDGES),
		.COORD_WIDTH (COORD_WIDTH),
		.CMD_W       (CMD_W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.vertex_index (vertex_index),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.q_stat       (q_stat),
		.push         (push),
		.push_data    (push_data)
	);

	// decouple the front end from the edge walk
	wnp_queue #(
		.DATA_W (CMD_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	// store vertices, walk edges, accumulate crossings
	wnp_back #(
		.MAX_EDGES   (MAX_EDGES),
		.COORD_WIDTH (COORD_WIDTH),
		.CMD_W       (CMD_W)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_stat         (q_stat),
		.pop_data       (pop_data),
		.pop            (pop),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.done           (done),
		.winding_number (winding_number),
		.inside_res     (inside_res)
	);

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the winding-number point-in-polygon block.
module testbench;
	import wnp_pkg::*;

	localparam int MAXE    = DEF_MAX_EDGES;
	localparam int COORD_W = DEF_COORD_WIDTH;
	localparam int IDX_W   = idx_w(DEF_MAX_EDGES);
	localparam int CNT_W   = cnt_w(DEF_MAX_EDGES);

	// Settling margin for the longest test walk, with room for queued writes.
	localparam int SETTLE_CYCLES  = 32;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int ITEM_TARGET    = 800;

	// What the request queue holds: a request for the block, a write of
	// edge_count, or a pause until the block has gone quiet.
	typedef enum logic [1:0] {
		ENT_REQ,
		ENT_CFG,
		ENT_DRAIN
	} entry_kind_t;

	typedef struct packed {
		entry_kind_t             kind;
		cmd_kind_t               cmd;
		logic [IDX_W-1:0]        idx;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [CNT_W-1:0]        cnt;
	} poly_req_t;

	typedef struct packed {
		logic signed [WN_W-1:0] wn;
		logic                   in_flag;
	} wind_res_t;

	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b0;
	logic                      start        = 1'b0;
	logic                      busy;
	logic                      req_type     = 1'b0;
	logic [IDX_W-1:0]          vertex_index = '0;
	logic signed [COORD_W-1:0] coord_x      = '0;
	logic signed [COORD_W-1:0] coord_y      = '0;
	logic                      cfg_valid    = 1'b0;
	logic                      cfg_ready;
	logic [CNT_W-1:0]          cfg_data     = '0;
	logic                      done;
	logic signed [WN_W-1:0]    winding_number;
	logic                      inside_res;

	winding_number_point_in_polygon dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.vertex_index  (vertex_index),
		.coord_x       (coord_x),
		.coord_y       (coord_y),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.done          (done),
		.winding_number(winding_number),
		.inside_res    (inside_res)
	);

	// Pending requests, filled up front; results still owed by the block.
	poly_req_t req_q[$];
	wind_res_t wind_exp_q[$];

	// Polygon store and edge count as the block should see them.
	logic signed [COORD_W-1:0] poly_x[0:MAXE];
	logic signed [COORD_W-1:0] poly_y[0:MAXE];
	logic [CNT_W-1:0]          edge_cnt = CNT_W'(EDGE_COUNT_RESET);

	// Vertices as the stimulus generator last wrote them, to aim query points.
	logic signed [COORD_W-1:0] gen_x[0:MAXE];
	logic signed [COORD_W-1:0] gen_y[0:MAXE];

	int item_total    = 0;
	int accepted_reqs = 0;
	int quiet_cycles  = 0;
	int err_cnt       = 0;
	int stall_cycles  = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Walk every edge below the clamped edge count and apply the crossing rule.
	// The side test is exact: 17-bit differences, 35-bit cross product.
	function automatic wind_res_t winding_of(input logic signed [COORD_W-1:0] px,
			input logic signed [COORD_W-1:0] py);
		int                          n;
		int                          wn;
		logic signed [COORD_W:0]     ex, ey, qx, qy;
		logic signed [2*COORD_W+2:0] side;
		wind_res_t                   res;
		n  = (edge_cnt > MAXE) ? MAXE : int'(edge_cnt);
		wn = 0;
		for (int i = 0; i < n; i++) begin
			ex   = poly_x[i+1] - poly_x[i];
			ey   = poly_y[i+1] - poly_y[i];
			qx   = px - poly_x[i];
			qy   = py - poly_y[i];
			side = ex * qy - qx * ey;
			if (poly_y[i] <= py) begin
				// upward crossing, point strictly left
				if (poly_y[i+1] > py && side > 0)
					wn++;
			end else if (poly_y[i+1] <= py && side < 0) begin
				// downward crossing, point strictly right
				wn--;
			end
		end
		if (wn > WN_MAX)
			wn = WN_MAX;
		if (wn < WN_MIN)
			wn = WN_MIN;
		res.wn      = wn[WN_W-1:0];
		res.in_flag = (wn != 0);
		return res;
	endfunction

	// ---------------------------------------------------------------
	// Stimulus construction
	// ---------------------------------------------------------------
	task automatic add_req(input cmd_kind_t cmd, input int idx,
			input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y);
		poly_req_t r;
		r.kind = ENT_REQ;
		r.cmd  = cmd;
		r.idx  = idx[IDX_W-1:0];
		r.x    = x;
		r.y    = y;
		r.cnt  = '0;
		req_q.insert(req_q.size(), r);
		if (cmd == CMD_TEST || idx <= MAXE)
			item_total++;
		if (cmd == CMD_WRITE && idx <= MAXE) begin
			gen_x[idx] = x;
			gen_y[idx] = y;
		end
	endtask

	task automatic add_test(input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y);
		add_req(CMD_TEST, $urandom_range(31), x, y);
	endtask

	// Hold off until every owed result is in and the block has settled,
	// then optionally rewrite edge_count.
	task automatic add_drain_cfg(input bit with_cfg, input int cnt);
		poly_req_t r;
		r.cmd = CMD_WRITE;
		r.idx = '0;
		r.x   = '0;
		r.y   = '0;
		r.cnt = cnt[CNT_W-1:0];
		r.kind = ENT_DRAIN;
		req_q.insert(req_q.size(), r);
		if (with_cfg) begin
			r.kind = ENT_CFG;
			req_q.insert(req_q.size(), r);
		end
	endtask

	function automatic logic signed [COORD_W-1:0] pick_coord(input int mode);
		int v;
		case (mode)
		0: v = $urandom_range(65535);
		1: v = int'($urandom_range(80)) - 40;
		default: v = int'($urandom_range(4000)) - 2000;
		endcase
		return v[COORD_W-1:0];
	endfunction

	// One phase: new edge count, a full polygon (mostly closed), then tests
	// with a little noise: stray writes out of range and vertex rewrites.
	task automatic build_phase(input int cnt);
		int ne, mode, ntest, k, r;
		ne   = (cnt > MAXE) ? MAXE : cnt;
		mode = $urandom_range(2);
		add_drain_cfg(1'b1, cnt);
		for (int i = 0; i < ne; i++)
			add_req(CMD_WRITE, i, pick_coord(mode), pick_coord(mode));
		if (ne != 0) begin
			if ($urandom_range(99) < 85)
				add_req(CMD_WRITE, ne, gen_x[0], gen_y[0]);
			else
				add_req(CMD_WRITE, ne, pick_coord(mode), pick_coord(mode));
		end
		ntest = $urandom_range(30, 8);
		for (int t = 0; t < ntest; t++) begin
			r = $urandom_range(99);
			k = $urandom_range(ne);
			if (r < 4)
				add_req(CMD_WRITE, $urandom_range(31, MAXE + 1), pick_coord(0), pick_coord(0));
			else if (r < 8)
				add_req(CMD_WRITE, k, pick_coord(mode), pick_coord(mode));
			else if (r < 22)
				add_test(gen_x[k], gen_y[k]);
			else if (r < 36)
				add_test(pick_coord(mode), gen_y[k]);
			else
				add_test(pick_coord(mode), pick_coord(mode));
		end
	endtask

	// ---------------------------------------------------------------
	// Driver: offer the head of the request queue, predict on acceptance
	// ---------------------------------------------------------------
	always @(posedge clk) begin : drive
		logic      nxt_start;
		logic      nxt_cfg;
		int        idle_pct;
		poly_req_t head;
		if (arst_n) begin
			nxt_start = start;
			nxt_cfg   = cfg_valid;

			// Retire a request taken at this edge and predict what it owes.
			if (start && !busy) begin
				if (req_type == CMD_WRITE) begin
					if (vertex_index <= MAXE) begin
						poly_x[vertex_index] = coord_x;
						poly_y[vertex_index] = coord_y;
					end
				end else begin
					wind_exp_q.insert(wind_exp_q.size(), winding_of(coord_x, coord_y));
				end
				void'(req_q.pop_front());
				accepted_reqs++;
				nxt_start = 1'b0;
			end

			// Retire an edge_count write.
			if (cfg_valid && cfg_ready) begin
				edge_cnt = cfg_data;
				void'(req_q.pop_front());
				nxt_cfg = 1'b0;
			end

			// Track how long the block has owed nothing and taken nothing.
			if (start && !busy)
				quiet_cycles = 0;
			else if (wind_exp_q.size() == 0)
				quiet_cycles++;
			else
				quiet_cycles = 0;

			// Sender idling: moderate, then heavy, then none.
			if (accepted_reqs < 270)
				idle_pct = 28;
			else if (accepted_reqs < 540)
				idle_pct = 87;
			else
				idle_pct = 0;

			// Advance to the next entry once nothing is on offer.
			if (!nxt_start && !nxt_cfg && req_q.size() != 0) begin
				head = req_q[0];
				case (head.kind)
				ENT_DRAIN: begin
					if (quiet_cycles >= SETTLE_CYCLES)
						void'(req_q.pop_front());
				end
				ENT_CFG: begin
					nxt_cfg  = 1'b1;
					cfg_data <= head.cnt;
				end
				default: begin
					if ($urandom_range(99) >= idle_pct) begin
						nxt_start    = 1'b1;
						req_type     <= head.cmd;
						vertex_index <= head.idx;
						coord_x      <= head.x;
						coord_y      <= head.y;
					end
				end
				endcase
			end

			start     <= nxt_start;
			cfg_valid <= nxt_cfg;
		end
	end

	// ---------------------------------------------------------------
	// Monitor: each done strobe must match the oldest owed result
	// ---------------------------------------------------------------
	always @(posedge clk) begin : check
		wind_res_t want;
		if (arst_n && done) begin
			if (wind_exp_q.size() == 0) begin
				if (err_cnt < 10)
					$display("unexpected result: winding %0d inside %0b",
						winding_number, inside_res);
				err_cnt++;
			end else begin
				want = wind_exp_q.pop_front();
				if (winding_number !== want.wn || inside_res !== want.in_flag) begin
					if (err_cnt < 10)
						$display("result mismatch: winding exp %0d got %0d, inside exp %0b got %0b",
							want.wn, winding_number, want.in_flag, inside_res);
					err_cnt++;
				end
			end
		end
	end

	// Drop the run if nothing moves for too long.
	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((start && !busy) || (cfg_valid && cfg_ready) || done)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Sequence: directed square checks, then random phases
	// ---------------------------------------------------------------
	initial begin : sequence_main
		int phase;
		int cnt;

		// Counter-clockwise square at the coordinate extremes, default edge count.
		add_req(CMD_WRITE, 0, 16'sh8000, 16'sh8000);
		add_req(CMD_WRITE, 1, 16'sh7FFF, 16'sh8000);
		add_req(CMD_WRITE, 2, 16'sh7FFF, 16'sh7FFF);
		add_req(CMD_WRITE, 3, 16'sh8000, 16'sh7FFF);
		add_req(CMD_WRITE, 4, 16'sh8000, 16'sh8000);
		add_test(16'sh0000, 16'sh0000);
		add_test(16'sh8000, 16'sh8000);
		add_test(16'sh7FFF, 16'sh7FFF);
		add_test(16'sh8000, 16'sh0000);
		add_test(16'sh7FFF, 16'sh0000);
		add_test(16'sh0000, 16'sh7FFF);
		// Writes past the store must be dropped.
		add_req(CMD_WRITE, MAXE + 1, 16'sh0000, 16'sh0000);
		add_req(CMD_WRITE, 31, 16'sh1234, 16'shEDCB);
		add_test(16'sh0001, 16'shFFFF);
		// Reverse the orientation: winding goes negative.
		add_req(CMD_WRITE, 1, 16'sh8000, 16'sh7FFF);
		add_req(CMD_WRITE, 3, 16'sh7FFF, 16'sh8000);
		add_test(16'sh0000, 16'sh0000);
		// Zero edge count tests nothing.
		add_drain_cfg(1'b1, 0);
		add_test(16'sh0000, 16'sh0000);

		// Random phases; the first ones force the count extremes and
		// saturation, the first of them fills every slot.
		phase = 0;
		while (item_total < ITEM_TARGET) begin
			case (phase)
			0: cnt = 31;
			1: cnt = MAXE;
			2: cnt = 1;
			3: cnt = 0;
			4: cnt = 3;
			default: cnt = (phase % 5 == 0) ? $urandom_range(31) : $urandom_range(MAXE, 1);
			endcase
			build_phase(cnt);
			phase++;
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Wait out the queue and every owed result, then let stragglers show.
		while (req_q.size() != 0 || start || cfg_valid || wind_exp_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (err_cnt == 0 && wind_exp_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ winding_number_point_in_polygon.f @@
rtl/wnp_pkg.sv
rtl/wnp_front.sv
rtl/wnp_queue.sv
rtl/wnp_back.sv
rtl/winding_number_point_in_polygon.sv
tb/testbench.sv
